### rtl/core/fcr_pkg.sv
// ----------------------------------------------------------------------------
// Framed command receiver package
// Shared widths, frame byte codes, parser phases, the launch struct passed
// between the parser and the response transmitter, and the configuration struct.
// ----------------------------------------------------------------------------
package fcr_pkg;

   localparam int unsigned ByteW    = 8;
   localparam int unsigned CsrIdxW  = 2;
   localparam int unsigned CsrDataW = 8;
   localparam int unsigned FanW     = 2;
   localparam int unsigned TxIdxW   = 3;

   // frame delimiters
   localparam logic [ByteW-1:0] BYTE_START = 8'h02;
   localparam logic [ByteW-1:0] BYTE_END   = 8'h03;
   localparam logic [ByteW-1:0] BYTE_ZERO  = 8'h00;

   // command codes
   localparam logic [ByteW-1:0] OP_FAN    = 8'h10;
   localparam logic [ByteW-1:0] OP_VALVE  = 8'h20;
   localparam logic [ByteW-1:0] OP_SIREN  = 8'h30;
   localparam logic [ByteW-1:0] OP_STATUS = 8'h40;
   localparam logic [ByteW-1:0] OP_GAS    = 8'h50;
   localparam logic [ByteW-1:0] OP_MAX    = 8'h60;
   localparam logic [ByteW-1:0] OP_CLEAR  = 8'h70;

   // length field of the status reply
   localparam logic [ByteW-1:0] STATUS_LEN = 8'h03;

   // index of the final word of each reply
   localparam logic [TxIdxW-1:0] ACK_LAST_IDX    = 3'd4;
   localparam logic [TxIdxW-1:0] STATUS_LAST_IDX = 3'd7;

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_LEN   = 3'd1,
      PH_CMD   = 3'd2,
      PH_DATA  = 3'd3,
      PH_CHECK = 3'd4,
      PH_END   = 3'd5
   } phase_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_FAN_LEVEL  = 2'd0,
      CSR_VALVE_OPEN = 2'd1,
      CSR_SIREN_ON   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             start;
      logic             status;
      logic [ByteW-1:0] command;
   } launch_type;

   typedef struct packed {
      logic [FanW-1:0] fan_level;
      logic            valve_open;
      logic            siren_on;
   } cfg_type;

   function automatic logic is_control(input logic [ByteW-1:0] cmd);
      is_control = (cmd == OP_FAN) || (cmd == OP_VALVE) || (cmd == OP_SIREN) ||
                   (cmd == OP_GAS) || (cmd == OP_MAX)   || (cmd == OP_CLEAR);
   endfunction

endpackage

### rtl/core/fcr_req_if.sv
// ----------------------------------------------------------------------------
// Receive channel
// Valid/ready channel carrying one received serial byte per word.
// ----------------------------------------------------------------------------
interface fcr_req_if;
   import fcr_pkg::*;

   logic             valid;
   logic             ready;
   logic [ByteW-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/core/fcr_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one response byte and its frame end flag.
// ----------------------------------------------------------------------------
interface fcr_rsp_if;
   import fcr_pkg::*;

   logic             valid;
   logic             ready;
   logic [ByteW-1:0] tx_byte;
   logic             tx_last;

   modport source (output valid, output tx_byte, output tx_last, input ready);
   modport sink   (input valid, input tx_byte, input tx_last, output ready);
endinterface

### rtl/core/fcr_csr_if.sv
// ----------------------------------------------------------------------------
// Register write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface fcr_csr_if;
   import fcr_pkg::*;

   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  reg_index;
   logic [CsrDataW-1:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

### rtl/core/framed_command_receiver_responder.sv
// ----------------------------------------------------------------------------
// Framed command receiver and responder
// Parses framed serial commands and answers valid ones with a reply frame.
// ----------------------------------------------------------------------------
// req_chan takes one received byte per word: start 0x02, length, command,
// payload, XOR check, end 0x03. Payload bytes are checked, not stored.
// rsp_chan returns the reply, one byte per word, tx_last on the final word:
// five words for a control command, eight for a status request.
// csr_chan writes fan level, valve and siren state reported in the status
// reply; it is always ready. The user must write it only while the block is
// idle; the block does not enforce this. Throughput: one received word per
// cycle, but the end byte waits while a reply drains. The first reply word is
// valid in the cycle after the end byte is taken. One counter ends a reply.
// A stalled receiver on rsp_chan holds the reply; received words are still
// taken until the next end byte, which waits until the reply has drained.
// Reset returns the parser to hunting for a start byte, drops any reply and
// sets fan level 1, valve open, siren off.
// ----------------------------------------------------------------------------
module framed_command_receiver_responder (
   input  logic      clock,
   input  logic      reset,
   fcr_req_if.sink   req_chan,
   fcr_rsp_if.source rsp_chan,
   fcr_csr_if.sink   csr_chan
);
   import fcr_pkg::*;

   launch_type launch;
   logic       tx_busy;

   fcr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .tx_busy (tx_busy),
      .launch  (launch)
   );

   fcr_tx u_tx (
      .clock  (clock),
      .reset  (reset),
      .rsp    (rsp_chan),
      .csr    (csr_chan),
      .launch (launch),
      .busy   (tx_busy)
   );
endmodule

### rtl/core/fcr_parser.sv
// ----------------------------------------------------------------------------
// Frame parser
// Tracks the frame phase, folds the XOR check and launches a reply to the
// transmitter when a well-formed frame with a known command ends.
// ----------------------------------------------------------------------------
module fcr_parser (
   input  logic               clock,
   input  logic               reset,
   fcr_req_if.sink            req,
   input  logic               tx_busy,
   output fcr_pkg::launch_type launch
);
   import fcr_pkg::*;

   phase_type        phase_ff,  phase_in;
   logic [ByteW-1:0] length_ff, length_in;
   logic [ByteW-1:0] cmd_ff,    cmd_in;
   logic [ByteW-1:0] count_ff,  count_in;
   logic [ByteW-1:0] run_ff,    run_in;
   logic [ByteW-1:0] rcv_ff,    rcv_in;
   logic [ByteW-1:0] count_inc;
   logic             accept;

   // hold the end byte back while the previous reply is still going out
   assign req.ready = !((phase_ff == PH_END) && tx_busy);
   assign accept    = req.valid && req.ready;
   assign count_inc = count_ff + 8'd1;

   // next state
   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      cmd_in    = cmd_ff;
      count_in  = count_ff;
      run_in    = run_ff;
      rcv_in    = rcv_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_LEN: begin
               length_in = req.rx_byte;
               run_in    = run_ff ^ req.rx_byte;
               count_in  = '0;
               phase_in  = PH_CMD;
            end
            PH_CMD: begin
               cmd_in   = req.rx_byte;
               run_in   = run_ff ^ req.rx_byte;
               phase_in = (length_ff != '0) ? PH_DATA : PH_CHECK;
            end
            PH_DATA: begin
               run_in   = run_ff ^ req.rx_byte;
               count_in = count_inc;
               if (count_inc >= length_ff) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               rcv_in   = req.rx_byte;
               phase_in = PH_END;
            end
            PH_END: begin
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
               if (req.rx_byte == BYTE_START) begin
                  phase_in = PH_LEN;
                  run_in   = '0;
               end
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      launch.command = cmd_ff;
      launch.status  = (cmd_ff == OP_STATUS);
      launch.start   = accept && (phase_ff == PH_END) && (req.rx_byte == BYTE_END) &&
                       (run_ff == rcv_ff) && ((cmd_ff == OP_STATUS) || is_control(cmd_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         length_ff <= '0;
         cmd_ff    <= '0;
         count_ff  <= '0;
         run_ff    <= '0;
         rcv_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         cmd_ff    <= cmd_in;
         count_ff  <= count_in;
         run_ff    <= run_in;
         rcv_ff    <= rcv_in;
      end
   end

`ifndef SYNTHESIS
   a_launch_idle: assert property (@(posedge clock) disable iff (reset)
      launch.start |-> !tx_busy)
      else $error("reply launched while transmitter busy");
   a_data_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (length_ff != '0))
      else $error("payload phase with zero length");
   a_data_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (count_ff < length_ff))
      else $error("payload count overran length");
`endif
endmodule

### rtl/core/fcr_tx.sv
// ----------------------------------------------------------------------------
// Response transmitter
// Holds the configuration registers and sends the acknowledge or status
// reply one word at a time.
// ----------------------------------------------------------------------------
module fcr_tx (
   input  logic               clock,
   input  logic               reset,
   fcr_rsp_if.source          rsp,
   fcr_csr_if.sink            csr,
   input  fcr_pkg::launch_type launch,
   output logic               busy
);
   import fcr_pkg::*;

   cfg_type           cfg_ff,    cfg_in;
   logic              busy_ff,   busy_in;
   logic              status_ff, status_in;
   logic [ByteW-1:0]  cmd_ff,    cmd_in;
   logic [TxIdxW-1:0] idx_ff,    idx_in;
   logic [ByteW-1:0]  fan_byte, valve_byte, siren_byte, status_chk;
   logic              last;

   assign csr.ready = 1'b1;
   assign busy      = busy_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         if (csr.reg_index == CSR_FAN_LEVEL) begin
            cfg_in.fan_level = csr.wr_data[FanW-1:0];
         end else if (csr.reg_index == CSR_VALVE_OPEN) begin
            cfg_in.valve_open = csr.wr_data[0];
         end else if (csr.reg_index == CSR_SIREN_ON) begin
            cfg_in.siren_on = csr.wr_data[0];
         end
      end
   end

   assign fan_byte   = {{(ByteW-FanW){1'b0}}, cfg_ff.fan_level};
   assign valve_byte = {{(ByteW-1){1'b0}}, cfg_ff.valve_open};
   assign siren_byte = {{(ByteW-1){1'b0}}, cfg_ff.siren_on};
   assign status_chk = STATUS_LEN ^ OP_STATUS ^ fan_byte ^ valve_byte ^ siren_byte;
   assign last       = status_ff ? (idx_ff == STATUS_LAST_IDX) : (idx_ff == ACK_LAST_IDX);

   always_comb begin
      busy_in   = busy_ff;
      status_in = status_ff;
      cmd_in    = cmd_ff;
      idx_in    = idx_ff;
      if (launch.start) begin
         busy_in   = 1'b1;
         status_in = launch.status;
         cmd_in    = launch.command;
         idx_in    = '0;
      end else if (busy_ff && rsp.ready) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_comb begin
      rsp.valid   = busy_ff;
      rsp.tx_last = last;
      rsp.tx_byte = BYTE_ZERO;
      if (status_ff) begin
         unique case (idx_ff)
            3'd0:    rsp.tx_byte = BYTE_START;
            3'd1:    rsp.tx_byte = STATUS_LEN;
            3'd2:    rsp.tx_byte = OP_STATUS;
            3'd3:    rsp.tx_byte = fan_byte;
            3'd4:    rsp.tx_byte = valve_byte;
            3'd5:    rsp.tx_byte = siren_byte;
            3'd6:    rsp.tx_byte = status_chk;
            default: rsp.tx_byte = BYTE_END;
         endcase
      end else begin
         unique case (idx_ff)
            3'd0:    rsp.tx_byte = BYTE_START;
            3'd1:    rsp.tx_byte = BYTE_ZERO;
            3'd2:    rsp.tx_byte = cmd_ff;
            3'd3:    rsp.tx_byte = cmd_ff;
            default: rsp.tx_byte = BYTE_END;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fan_level  <= 2'd1;
         cfg_ff.valve_open <= 1'b1;
         cfg_ff.siren_on   <= 1'b0;
         busy_ff           <= 1'b0;
         status_ff         <= 1'b0;
         idx_ff            <= '0;
      end else begin
         cfg_ff    <= cfg_in;
         busy_ff   <= busy_in;
         status_ff <= status_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

`ifndef SYNTHESIS
   a_ack_range: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !status_ff) |-> (idx_ff <= ACK_LAST_IDX))
      else $error("acknowledge index past final word");
   a_load_first: assert property (@(posedge clock) disable iff (reset)
      launch.start |=> (busy_ff && (idx_ff == '0)))
      else $error("reply did not start at first word");
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && rsp.ready && last) |=> !busy_ff)
      else $error("transmitter still busy after final word");
`endif
endmodule
